// ===== src/q2r_pkg.sv =====
// ----------------------------------------------------------------------------
// q2r_pkg
// Shared widths, constants and the queue item type of the quaternion to
// rotation matrix block.
// ----------------------------------------------------------------------------
package q2r_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = DATA_WIDTH - 2;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int N_W        = 2 * DATA_WIDTH + 1;
    localparam int NUM_EL     = 9;
    localparam int STEPS      = FRAC_BITS + 2;
    localparam int Q_W        = STEPS;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic [DATA_WIDTH-1:0] ONE_FX = {2'b01, {FRAC_BITS{1'b0}}};

    // element order, row major
    localparam int M00 = 0;
    localparam int M01 = 1;
    localparam int M02 = 2;
    localparam int M10 = 3;
    localparam int M11 = 4;
    localparam int M12 = 5;
    localparam int M20 = 6;
    localparam int M21 = 7;
    localparam int M22 = 8;

    localparam logic [NUM_EL-1:0] DIAG_MASK = 9'b100010001;

    typedef struct packed {
        logic                          deg;
        logic [N_W-1:0]                n;
        logic [NUM_EL-1:0]             neg;
        logic [NUM_EL-1:0][N_W-1:0]    mag;
    } q2r_item_t;

endpackage

// ===== src/q2r_front.sv =====
// ----------------------------------------------------------------------------
// q2r_front
// Forms the ten products, the squared norm and the nine signed numerators
// (as sign and magnitude) in two pipeline stages.
// ----------------------------------------------------------------------------
module q2r_front (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [q2r_pkg::DATA_WIDTH-1:0] in_w,
    input  logic signed [q2r_pkg::DATA_WIDTH-1:0] in_x,
    input  logic signed [q2r_pkg::DATA_WIDTH-1:0] in_y,
    input  logic signed [q2r_pkg::DATA_WIDTH-1:0] in_z,
    output logic                                  item_valid,
    input  logic                                  item_ready,
    output q2r_pkg::q2r_item_t                    item
);

    localparam int PW = q2r_pkg::PROD_W;
    localparam int NW = q2r_pkg::N_W;

    logic v1_reg, v2_reg;
    logic adv1, adv2;
    logic signed [PW-1:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [PW-1:0] xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;
    q2r_pkg::q2r_item_t item_reg, item_next;

    assign adv2     = !v2_reg || item_ready;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
        end
        if (adv1) begin
            ww_reg <= in_w * in_w;
            xx_reg <= in_x * in_x;
            yy_reg <= in_y * in_y;
            zz_reg <= in_z * in_z;
            xy_reg <= in_x * in_y;
            xz_reg <= in_x * in_z;
            yz_reg <= in_y * in_z;
            wx_reg <= in_w * in_x;
            wy_reg <= in_w * in_y;
            wz_reg <= in_w * in_z;
        end
        if (adv2) item_reg <= item_next;
    end

    always_comb begin
        logic signed [NW:0] sw, sx, sy, sz, sxy, sxz, syz, swx, swy, swz;
        logic signed [NW:0] d [q2r_pkg::NUM_EL];
        logic [NW:0] nsum;
        sw  = (NW+1)'(ww_reg);
        sx  = (NW+1)'(xx_reg);
        sy  = (NW+1)'(yy_reg);
        sz  = (NW+1)'(zz_reg);
        sxy = (NW+1)'(xy_reg);
        sxz = (NW+1)'(xz_reg);
        syz = (NW+1)'(yz_reg);
        swx = (NW+1)'(wx_reg);
        swy = (NW+1)'(wy_reg);
        swz = (NW+1)'(wz_reg);
        nsum = sw + sx + sy + sz;
        // off-diagonal numerators carry the factor of two
        d[q2r_pkg::M00] = sw + sx - sy - sz;
        d[q2r_pkg::M01] = (sxy - swz) <<< 1;
        d[q2r_pkg::M02] = (sxz + swy) <<< 1;
        d[q2r_pkg::M10] = (sxy + swz) <<< 1;
        d[q2r_pkg::M11] = sw - sx + sy - sz;
        d[q2r_pkg::M12] = (syz - swx) <<< 1;
        d[q2r_pkg::M20] = (sxz - swy) <<< 1;
        d[q2r_pkg::M21] = (syz + swx) <<< 1;
        d[q2r_pkg::M22] = sw - sx - sy + sz;
        item_next.n   = nsum[NW-1:0];
        item_next.deg = (nsum == '0);
        for (int i = 0; i < q2r_pkg::NUM_EL; i++) begin
            item_next.neg[i] = d[i][NW];
            item_next.mag[i] = d[i][NW] ? NW'(-d[i]) : NW'(d[i]);
        end
    end

    assign item_valid = v2_reg;
    assign item       = item_reg;

endmodule

// ===== src/q2r_fifo.sv =====
// ----------------------------------------------------------------------------
// q2r_fifo
// Short queue of prepared items between the front and the divider array.
// ----------------------------------------------------------------------------
module q2r_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  q2r_pkg::q2r_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output q2r_pkg::q2r_item_t out_item
);

    localparam int AW = q2r_pkg::FIFO_AW;

    q2r_pkg::q2r_item_t mem_reg [q2r_pkg::FIFO_DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   count_reg;
    logic push, pop;

    assign in_ready  = (count_reg != (AW+1)'(q2r_pkg::FIFO_DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
        if (push) mem_reg[wr_ptr_reg] <= in_item;
    end

endmodule

// ===== src/q2r_back.sv =====
// ----------------------------------------------------------------------------
// q2r_back
// Nine lanes of pipelined restoring division, one quotient bit per stage,
// then rounding, sign and the zero quaternion override in the output register.
// ----------------------------------------------------------------------------
module q2r_back (
    input  logic                                                 aclk,
    input  logic                                                 aresetn,
    input  logic                                                 item_valid,
    output logic                                                 item_ready,
    input  q2r_pkg::q2r_item_t                                   item,
    output logic                                                 m_valid,
    input  logic                                                 m_ready,
    output logic [q2r_pkg::NUM_EL-1:0][q2r_pkg::DATA_WIDTH-1:0]  m_el,
    output logic                                                 m_deg
);

    localparam int NW = q2r_pkg::N_W;
    localparam int QW = q2r_pkg::Q_W;
    localparam int ST = q2r_pkg::STEPS;
    localparam int NE = q2r_pkg::NUM_EL;
    localparam int DW = q2r_pkg::DATA_WIDTH;

    logic              v_reg   [ST];
    logic              adv     [ST+1];
    logic [NW-1:0]     n_reg   [ST];
    logic              deg_reg [ST];
    logic [NE-1:0]     neg_reg [ST];
    logic [NW:0]       r_reg   [ST][NE];
    logic [QW-1:0]     q_reg   [ST][NE];

    logic                      out_valid_reg;
    logic [NE-1:0][DW-1:0]     el_reg, el_next;
    logic                      out_deg_reg;

    assign adv[ST]    = !out_valid_reg || m_ready;
    assign item_ready = adv[0];

    for (genvar s = 0; s < ST; s++) begin : g_stage
        logic          src_v;
        logic [NW-1:0] src_n;
        logic          src_deg;
        logic [NE-1:0] src_neg;
        logic [NW:0]   src_r  [NE];
        logic [QW-1:0] src_q  [NE];
        logic [NW:0]   r_next [NE];
        logic [QW-1:0] q_next [NE];

        assign adv[s] = !v_reg[s] || adv[s+1];

        if (s == 0) begin : g_src
            always_comb begin
                src_v   = item_valid;
                src_n   = item.n;
                src_deg = item.deg;
                src_neg = item.neg;
                for (int i = 0; i < NE; i++) begin
                    src_r[i] = {1'b0, item.mag[i]};
                    src_q[i] = '0;
                end
            end
        end else begin : g_src
            always_comb begin
                src_v   = v_reg[s-1];
                src_n   = n_reg[s-1];
                src_deg = deg_reg[s-1];
                src_neg = neg_reg[s-1];
                for (int i = 0; i < NE; i++) begin
                    src_r[i] = r_reg[s-1][i];
                    src_q[i] = q_reg[s-1][i];
                end
            end
        end

        // first step tests the numerator itself, later ones the doubled remainder
        always_comb begin
            logic [NW:0] sh;
            logic        ge;
            for (int i = 0; i < NE; i++) begin
                sh = (s == 0) ? src_r[i] : (src_r[i] << 1);
                ge = (sh >= {1'b0, src_n});
                r_next[i] = ge ? (sh - {1'b0, src_n}) : sh;
                q_next[i] = {src_q[i][QW-2:0], ge};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[s] <= 1'b0;
            end else if (adv[s]) begin
                v_reg[s] <= src_v;
            end
            if (adv[s]) begin
                n_reg[s]   <= src_n;
                deg_reg[s] <= src_deg;
                neg_reg[s] <= src_neg;
                for (int i = 0; i < NE; i++) begin
                    r_reg[s][i] <= r_next[i];
                    q_reg[s][i] <= q_next[i];
                end
            end
        end
    end

    always_comb begin
        logic [QW:0]   rnd;
        logic [DW-1:0] mag;
        for (int i = 0; i < NE; i++) begin
            // one extra quotient bit, halved: round half away from zero
            rnd = ((QW+1)'(q_reg[ST-1][i]) + 1'b1) >> 1;
            mag = rnd[DW-1:0];
            if (rnd > (QW+1)'(q2r_pkg::ONE_FX)) mag = q2r_pkg::ONE_FX;
            if (deg_reg[ST-1]) begin
                el_next[i] = q2r_pkg::DIAG_MASK[i] ? q2r_pkg::ONE_FX : '0;
            end else begin
                el_next[i] = neg_reg[ST-1][i] ? (~mag + 1'b1) : mag;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv[ST]) begin
            out_valid_reg <= v_reg[ST-1];
        end
        if (adv[ST]) begin
            el_reg      <= el_next;
            out_deg_reg <= deg_reg[ST-1];
        end
    end

    assign m_valid = out_valid_reg;
    assign m_el    = el_reg;
    assign m_deg   = out_deg_reg;

endmodule

// ===== src/quaternion_to_rotation_matrix.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// Converts a Q1.14 quaternion (w, x, y, z) of any length to its 3x3 rotation
// matrix in Q1.14, each element rounded once, half away from zero.
//
// Input channel s_*: one quaternion per transaction, w in the lowest 16 bits
// of s_tdata, then x, y, z.
// Output channel m_*: nine elements in row-major order in m_tdata, element
// m00 lowest; m_tuser[0] flags a zero quaternion, for which the identity
// matrix is given.
// With no stall a transaction passes two stages that form products and
// numerators, one queue slot, sixteen divider stages that each resolve one
// quotient bit for all nine elements, and the output register.
// Throughput is one transaction per cycle while m_tready is high; the
// sixteen-stage division array sets the latency.
// Reset (aresetn low, synchronous) empties every stage and the queue.
// When m_tready is low the output register holds, bubbles in the pipeline
// still close up, and the four-entry queue keeps the front accepting until
// it fills; s_tready never depends combinationally on m_tready.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // fields from bit 0: in_w, in_x, in_y, in_z
    input  logic [4*q2r_pkg::DATA_WIDTH-1:0]            s_tdata,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // fields from bit 0: m00, m01, m02, m10, m11, m12, m20, m21, m22
    output logic [q2r_pkg::NUM_EL*q2r_pkg::DATA_WIDTH-1:0] m_tdata,
    // fields from bit 0: degenerate
    output logic [0:0]                                  m_tuser
);

    localparam int DW = q2r_pkg::DATA_WIDTH;

    logic               f_valid, f_ready, b_valid, b_ready;
    q2r_pkg::q2r_item_t f_item, b_item;
    logic [q2r_pkg::NUM_EL-1:0][DW-1:0] m_el;
    logic               m_deg;

    q2r_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_w       (s_tdata[DW-1:0]),
        .in_x       (s_tdata[2*DW-1:DW]),
        .in_y       (s_tdata[3*DW-1:2*DW]),
        .in_z       (s_tdata[4*DW-1:3*DW]),
        .item_valid (f_valid),
        .item_ready (f_ready),
        .item       (f_item)
    );

    q2r_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_item  (b_item)
    );

    q2r_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (b_valid),
        .item_ready (b_ready),
        .item       (b_item),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_el       (m_el),
        .m_deg      (m_deg)
    );

    assign m_tdata    = m_el;
    assign m_tuser[0] = m_deg;

    // zero quaternion gives ones on the diagonal and zeros in m01, m12 and m20
    a_deg_identity: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_deg |-> m_el[q2r_pkg::M00] == q2r_pkg::ONE_FX &&
            m_el[q2r_pkg::M11] == q2r_pkg::ONE_FX && m_el[q2r_pkg::M22] == q2r_pkg::ONE_FX &&
            m_el[q2r_pkg::M01] == '0 && m_el[q2r_pkg::M12] == '0 &&
            m_el[q2r_pkg::M20] == '0)
        else $error("degenerate result is not the identity");

    // elements m00 and m01 never leave plus or minus one
    a_el_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $signed(m_el[q2r_pkg::M01]) <= $signed(q2r_pkg::ONE_FX) &&
            $signed(m_el[q2r_pkg::M01]) >= -$signed(q2r_pkg::ONE_FX) &&
            $signed(m_el[q2r_pkg::M00]) <= $signed(q2r_pkg::ONE_FX) &&
            $signed(m_el[q2r_pkg::M00]) >= -$signed(q2r_pkg::ONE_FX))
        else $error("matrix element out of range");

    // an empty queue never refuses the front
    a_queue_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !b_valid |-> f_ready)
        else $error("empty queue refused a transaction");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

// ===== sim/tb_quaternion_to_rotation_matrix.sv =====
// ----------------------------------------------------------------------------
// tb_quaternion_to_rotation_matrix
// Sends quaternions over the input stream and compares every rotation matrix
// that comes back against a bit-exact predictor of the division and the
// half-away-from-zero rounding, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_quaternion_to_rotation_matrix;

    localparam int DW = q2r_pkg::DATA_WIDTH;

    typedef struct packed {
        logic                  deg;
        logic [8:0][DW-1:0]    el;
    } matrix_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [4*DW-1:0]       s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [9*DW-1:0]       m_tdata;
    logic [0:0]            m_tuser;

    matrix_t matrix_q[$];
    int      n_sent;
    int      n_recv;
    int      n_deg;
    int      n_mismatch;
    int      n_orphan;

    quaternion_to_rotation_matrix u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // round(mag * 2^k / n), ties away from zero, clamped to 1.0
    function automatic logic [DW-1:0] scaled_element(logic neg, logic [127:0] mag, int k,
                                                     logic [127:0] n);
        logic [127:0] q;
        logic [127:0] m;
        q = ((mag << (k + 1)) / n + 1) >> 1;
        if (q > (128'd1 << q2r_pkg::FRAC_BITS))
            q = 128'd1 << q2r_pkg::FRAC_BITS;
        m = neg ? -q : q;
        return m[DW-1:0];
    endfunction

    function automatic logic [DW-1:0] off_term(logic signed [127:0] a,
                                               logic signed [127:0] b, logic [127:0] n);
        logic               neg;
        logic signed [127:0] d;
        neg = a < b;
        d = neg ? b - a : a - b;
        return scaled_element(neg, d, q2r_pkg::FRAC_BITS + 1, n);
    endfunction

    function automatic matrix_t rotation_of(logic [4*DW-1:0] q);
        matrix_t             r;
        logic signed [127:0] w, x, y, z, n, p;
        w = $signed(q[0*DW +: DW]);
        x = $signed(q[1*DW +: DW]);
        y = $signed(q[2*DW +: DW]);
        z = $signed(q[3*DW +: DW]);
        r = '0;
        if (w == 0 && x == 0 && y == 0 && z == 0) begin
            r.deg = 1'b1;
            r.el[q2r_pkg::M00] = q2r_pkg::ONE_FX;
            r.el[q2r_pkg::M11] = q2r_pkg::ONE_FX;
            r.el[q2r_pkg::M22] = q2r_pkg::ONE_FX;
            return r;
        end
        n = w*w + x*x + y*y + z*z;
        p = w*w + x*x - y*y - z*z;
        r.el[q2r_pkg::M00] = scaled_element(p < 0, p < 0 ? -p : p, q2r_pkg::FRAC_BITS, n);
        p = w*w - x*x + y*y - z*z;
        r.el[q2r_pkg::M11] = scaled_element(p < 0, p < 0 ? -p : p, q2r_pkg::FRAC_BITS, n);
        p = w*w - x*x - y*y + z*z;
        r.el[q2r_pkg::M22] = scaled_element(p < 0, p < 0 ? -p : p, q2r_pkg::FRAC_BITS, n);
        r.el[q2r_pkg::M01] = off_term(x*y, w*z, n);
        r.el[q2r_pkg::M02] = off_term(x*z, -(w*y), n);
        r.el[q2r_pkg::M10] = off_term(x*y, -(w*z), n);
        r.el[q2r_pkg::M12] = off_term(y*z, w*x, n);
        r.el[q2r_pkg::M20] = off_term(x*z, w*y, n);
        r.el[q2r_pkg::M21] = off_term(y*z, -(w*x), n);
        return r;
    endfunction

    // valid stays high after a transaction; it drops only when a gap is drawn
    task automatic send_quaternion(logic [DW-1:0] w, logic [DW-1:0] x,
                                   logic [DW-1:0] y, logic [DW-1:0] z);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x, w};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        matrix_q.push_back(rotation_of({z, y, x, w}));
        n_sent++;
    endtask

    // random component: full range half the time, else tiny, extreme or zero
    function automatic logic [DW-1:0] rand_component();
        case ($urandom_range(0, 5))
            0:       return DW'($signed($urandom_range(0, 6)) - 3);
            1:       return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
            2:       return '0;
            default: return DW'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        send_quaternion(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_quaternion(16'h4000, 16'h0000, 16'h0000, 16'h0000);
        send_quaternion(16'h0000, 16'h4000, 16'h0000, 16'h0000);
        send_quaternion(16'h0000, 16'h0000, 16'h4000, 16'h0000);
        send_quaternion(16'h0000, 16'h0000, 16'h0000, 16'h4000);
        send_quaternion(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_quaternion(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_quaternion(16'h8000, 16'h0000, 16'h0000, 16'h0000);
        send_quaternion(16'h0000, 16'h8000, 16'h7fff, 16'h0000);
        send_quaternion(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        send_quaternion(16'h0001, 16'h0000, 16'h0000, 16'h0000);
        send_quaternion(16'h0000, 16'h0000, 16'h0000, 16'hffff);
        send_quaternion(16'h0001, 16'h0001, 16'h0001, 16'h0001);
        send_quaternion(16'h0001, 16'h0002, 16'h0003, 16'h0004);
        send_quaternion(16'hffff, 16'h0001, 16'hffff, 16'h0001);
        send_quaternion(16'h2d41, 16'h2d41, 16'h0000, 16'h0000);
        send_quaternion(16'h0003, 16'h0000, 16'h0000, 16'h0001);
        send_quaternion(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_quaternion(rand_component(), rand_component(), rand_component(),
                            rand_component());
    endtask

    task automatic test_drain_pause();
        s_tvalid <= 1'b0;
        while (matrix_q.size() != 0) @(posedge aclk);
        test_random(20);
    endtask

    task automatic test_back_to_back(int count);
        for (int i = 0; i < count; i++) begin
            s_tvalid <= 1'b1;
            s_tdata  <= {rand_component(), rand_component(), rand_component(),
                         rand_component()};
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            matrix_q.push_back(rotation_of(s_tdata));
            n_sent++;
        end
    endtask

    // result checker with random backpressure
    initial begin
        int      stall;
        matrix_t got;
        matrix_t want;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 16);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            got.el  = m_tdata;
            got.deg = m_tuser[0];
            n_recv++;
            if (got.deg) n_deg++;
            if (matrix_q.size() == 0) begin
                n_orphan++;
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected transaction: %h deg %b", got.el, got.deg);
            end else begin
                want = matrix_q.pop_front();
                if (got.deg !== want.deg) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("degenerate: expected %b actual %b", want.deg, got.deg);
                end
                for (int e = 0; e < 9; e++)
                    if (got.el[e] !== want.el[e]) begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display("element %0d: expected %0d actual %0d", e,
                                     $signed(want.el[e]), $signed(got.el[e]));
                    end
            end
        end
    end

    initial begin
        #3000000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        n_sent = 0; n_recv = 0; n_deg = 0; n_mismatch = 0; n_orphan = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(800);
        test_drain_pause();
        test_back_to_back(300);
        test_random(600);
        s_tvalid <= 1'b0;
        while (matrix_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        $display("%0d quaternions sent, %0d matrices checked, %0d zero-norm cases",
                 n_sent, n_recv, n_deg);
        if (n_mismatch == 0 && matrix_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
